FILE: hdl/packed_to_padded_fill_address_defines.svh
// Assertion macros shared by the padding-fill address generator.
`ifndef PACKED_TO_PADDED_FILL_ADDRESS_DEFINES_SVH
`define PACKED_TO_PADDED_FILL_ADDRESS_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PFA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define PFA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFA_ASSERT_IMP(label, ante, cons, msg)
`define PFA_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

FILE: hdl/pfa_pkg.sv
// Shared types and constants of the padding-fill address generator.
package pfa_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int LEN_W       = 16;
    localparam int IDX_W       = 31;
    localparam int COUNT_W     = 13;
    localparam int WORD_W      = 32;
    localparam int PLANE_W     = 2 * LEN_W;
    localparam int NUMEL_W     = 3 * LEN_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RANK        = 3'd0,
        CFG_LEN_A       = 3'd1,
        CFG_LEN_B       = 3'd2,
        CFG_LEN_C       = 3'd3,
        CFG_BATCH_COUNT = 3'd4,
        CFG_PAD_WORD    = 3'd5
    } cfg_idx_t;

    localparam logic [1:0] RANK_NONE = 2'd0;
    localparam logic [1:0] RANK_1D   = 2'd1;
    localparam logic [1:0] RANK_2D   = 2'd2;
    localparam logic [1:0] RANK_3D   = 2'd3;

    // Register file plus products derived from it.
    typedef struct packed {
        logic [1:0]         rank;
        logic [LEN_W-1:0]   len_a;
        logic [LEN_W-1:0]   len_b;
        logic [LEN_W-1:0]   len_c;
        logic [COUNT_W-1:0] batch_count;
        logic [WORD_W-1:0]  pad_word;
        logic [PLANE_W-1:0] plane;
        logic [NUMEL_W-1:0] numel;
    } cfg_t;

    // Per-item fields that ride along the pipeline.
    typedef struct packed {
        logic [LEN_W-1:0] ext3;
        logic [LEN_W-1:0] ext2;
        logic [LEN_W-1:0] ext1;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] idx;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

endpackage

FILE: hdl/pfa_cfg_regs.sv
// Configuration registers and the padded block products derived from them.
module pfa_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pfa_pkg::cfg_t                     cfg
);

    logic [1:0]                      rank_reg;
    logic [pfa_pkg::LEN_W-1:0]       len_a_reg;
    logic [pfa_pkg::LEN_W-1:0]       len_b_reg;
    logic [pfa_pkg::LEN_W-1:0]       len_c_reg;
    logic [pfa_pkg::COUNT_W-1:0]     batch_count_reg;
    logic [pfa_pkg::WORD_W-1:0]      pad_word_reg;
    logic [pfa_pkg::PLANE_W-1:0]     plane_reg;
    logic [pfa_pkg::NUMEL_W-1:0]     numel2_reg;
    logic [pfa_pkg::NUMEL_W-1:0]     numel3_reg;
    logic [pfa_pkg::NUMEL_W-1:0]     numel_reg;
    logic [pfa_pkg::NUMEL_W-1:0]     numel_next;
    logic [pfa_pkg::LEN_W-1:0]       data_len;

    assign data_len = cfg_data[pfa_pkg::LEN_W-1:0];

    always_comb
    begin
        unique case (rank_reg)
            pfa_pkg::RANK_NONE: numel_next = '0;
            pfa_pkg::RANK_1D:   numel_next = pfa_pkg::NUMEL_W'(len_a_reg);
            pfa_pkg::RANK_2D:   numel_next = numel2_reg;
            pfa_pkg::RANK_3D:   numel_next = numel3_reg;
        endcase
    end

    // plane tracks b*c exactly at the write; block sizes pass through numel2_reg or
    // numel3_reg, then numel_reg, well before any item reaches the stages that read them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg        <= pfa_pkg::RANK_1D;
            len_a_reg       <= pfa_pkg::LEN_W'(1);
            len_b_reg       <= pfa_pkg::LEN_W'(1);
            len_c_reg       <= pfa_pkg::LEN_W'(1);
            batch_count_reg <= '0;
            pad_word_reg    <= '0;
            plane_reg       <= pfa_pkg::PLANE_W'(1);
            numel2_reg      <= pfa_pkg::NUMEL_W'(1);
            numel3_reg      <= pfa_pkg::NUMEL_W'(1);
            numel_reg       <= pfa_pkg::NUMEL_W'(1);
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (pfa_pkg::cfg_idx_t'(cfg_index))
                    pfa_pkg::CFG_RANK:
                        rank_reg <= cfg_data[1:0];
                    pfa_pkg::CFG_LEN_A:
                        len_a_reg <= data_len;
                    pfa_pkg::CFG_LEN_B:
                    begin
                        len_b_reg <= data_len;
                        plane_reg <= pfa_pkg::PLANE_W'(data_len) *
                                     pfa_pkg::PLANE_W'(len_c_reg);
                    end
                    pfa_pkg::CFG_LEN_C:
                    begin
                        len_c_reg <= data_len;
                        plane_reg <= pfa_pkg::PLANE_W'(len_b_reg) *
                                     pfa_pkg::PLANE_W'(data_len);
                    end
                    pfa_pkg::CFG_BATCH_COUNT:
                        batch_count_reg <= cfg_data[pfa_pkg::COUNT_W-1:0];
                    pfa_pkg::CFG_PAD_WORD:
                        pad_word_reg <= cfg_data[pfa_pkg::WORD_W-1:0];
                    default:
                        ;
                endcase
            end
            numel2_reg <= pfa_pkg::NUMEL_W'(len_a_reg) * pfa_pkg::NUMEL_W'(len_b_reg);
            numel3_reg <= pfa_pkg::NUMEL_W'(len_a_reg) * pfa_pkg::NUMEL_W'(plane_reg);
            numel_reg  <= numel_next;
        end
    end

    always_comb
    begin
        cfg.rank        = rank_reg;
        cfg.len_a       = len_a_reg;
        cfg.len_b       = len_b_reg;
        cfg.len_c       = len_c_reg;
        cfg.batch_count = batch_count_reg;
        cfg.pad_word    = pad_word_reg;
        cfg.plane       = plane_reg;
        cfg.numel       = numel_reg;
    end

endmodule

FILE: hdl/pfa_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
module pfa_div_pipe
#(
    parameter int DVD_W  = 31,
    parameter int DVS_W  = 32,
    parameter int QUOT_W = 16,
    parameter int SIDE_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUOT_W-1:0] quotient,
    output logic [DVD_W-1:0]  remainder,
    output logic [SIDE_W-1:0] side_out
);

    // Quotient must fit in QUOT_W bits; otherwise the result is garbage
    // and the caller drops the item.
    localparam int WIDE_W = (DVD_W > DVS_W + QUOT_W) ? DVD_W : DVS_W + QUOT_W;

    logic [QUOT_W-1:0] valid_reg;
    logic [DVD_W-1:0]  rem_reg   [QUOT_W];
    logic [QUOT_W-1:0] quot_reg  [QUOT_W];
    logic [SIDE_W-1:0] side_reg  [QUOT_W];

    logic [QUOT_W-1:0] valid_src;
    logic [DVD_W-1:0]  rem_src   [QUOT_W];
    logic [QUOT_W-1:0] quot_src  [QUOT_W];
    logic [SIDE_W-1:0] side_src  [QUOT_W];
    logic [DVD_W-1:0]  rem_next  [QUOT_W];
    logic [QUOT_W-1:0] quot_next [QUOT_W];

    always_comb
    begin
        valid_src[0] = in_valid;
        rem_src[0]   = dividend;
        quot_src[0]  = '0;
        side_src[0]  = side_in;
        for (int s = 1; s < QUOT_W; s++)
        begin
            valid_src[s] = valid_reg[s-1];
            rem_src[s]   = rem_reg[s-1];
            quot_src[s]  = quot_reg[s-1];
            side_src[s]  = side_reg[s-1];
        end
    end

    // Stage s decides quotient bit QUOT_W-1-s.
    always_comb
    begin
        logic [WIDE_W-1:0] rem_w;
        logic [WIDE_W-1:0] trial_w;
        for (int s = 0; s < QUOT_W; s++)
        begin
            rem_w        = WIDE_W'(rem_src[s]);
            trial_w      = WIDE_W'(divisor) << (QUOT_W - 1 - s);
            rem_next[s]  = rem_src[s];
            quot_next[s] = quot_src[s];
            if (rem_w >= trial_w)
            begin
                rem_next[s]  = DVD_W'(rem_w - trial_w);
                quot_next[s] = quot_src[s] | (QUOT_W'(1) << (QUOT_W - 1 - s));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_src;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < QUOT_W; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                quot_reg[s] <= quot_next[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign quotient  = quot_reg[QUOT_W-1];
    assign remainder = rem_reg[QUOT_W-1];
    assign side_out  = side_reg[QUOT_W-1];

endmodule

FILE: hdl/pfa_addr_calc.sv
// Three-stage back end: bounds checks, offset products and final address sums.
module pfa_addr_calc
#(
    parameter int AW  = 31,
    parameter int BIW = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [BIW-1:0]            batch,
    input  pfa_pkg::item_t            item,
    input  logic [pfa_pkg::LEN_W-1:0] q1,
    input  logic [pfa_pkg::LEN_W-1:0] r1,
    input  logic [pfa_pkg::LEN_W-1:0] q2,
    input  logic [pfa_pkg::IDX_W-1:0] r2,
    input  pfa_pkg::cfg_t             cfg,
    output logic                      out_valid,
    output logic [AW-1:0]             dest_address,
    output logic [AW-1:0]             source_address,
    output logic                      is_padding,
    output logic [pfa_pkg::WORD_W-1:0] fill_word
);

    localparam int LW     = pfa_pkg::LEN_W;
    localparam int XW     = pfa_pkg::IDX_W;
    localparam int NHI_W  = (AW > 16) ? AW - 16 : 1;
    localparam int DLO_W  = BIW + 16;
    localparam int DHI_W  = BIW + NHI_W;
    localparam int CMP_W  = (BIW > pfa_pkg::COUNT_W) ? BIW : pfa_pkg::COUNT_W;
    localparam int SUM_W  = pfa_pkg::NUMEL_W;

    // Stage A
    logic                     a_valid_reg;
    logic                     a_keep_reg;
    logic                     a_inside_reg;
    logic [LW-1:0]            a_x0_reg;
    logic [LW-1:0]            a_x1_reg;
    logic [XW-1:0]            a_x2_reg;
    logic [LW-1:0]            a_e2_reg;
    logic [LW-1:0]            a_e3_reg;
    logic [2*LW-1:0]          a_e23_reg;
    logic [DLO_W-1:0]         a_dlo_reg;
    logic [DHI_W-1:0]         a_dhi_reg;
    logic [XW-1:0]            a_idx_reg;
    logic [XW-1:0]            a_base_reg;
    // Stage B
    logic                     b_valid_reg;
    logic                     b_keep_reg;
    logic                     b_inside_reg;
    logic [SUM_W-1:0]         b_m0_reg;
    logic [2*LW-1:0]          b_m1_reg;
    logic [XW:0]              b_bx_reg;
    logic [AW-1:0]            b_dest_reg;
    // Stage C
    logic                     c_valid_reg;
    logic [AW-1:0]            c_dest_reg;
    logic [AW-1:0]            c_src_reg;
    logic                     c_pad_reg;
    logic [pfa_pkg::WORD_W-1:0] c_fill_reg;

    logic [LW-1:0]            x0_next;
    logic [LW-1:0]            x1_next;
    logic [XW-1:0]            x2_next;
    logic                     dims_ok;
    logic                     rank_ok;
    logic                     in_range;
    logic                     real_batch;
    logic [63:0]              numel_w;
    logic [2*LW-1:0]          stride0;
    logic [SUM_W-1:0]         src_sum;

    assign numel_w = 64'(cfg.numel);

    always_comb
    begin
        x0_next = '0;
        x1_next = '0;
        x2_next = item.idx;
        dims_ok = item.idx < XW'(item.ext1);
        rank_ok = 1'b1;
        unique case (cfg.rank)
            pfa_pkg::RANK_NONE:
                rank_ok = 1'b0;
            pfa_pkg::RANK_1D:
                ;
            pfa_pkg::RANK_2D:
            begin
                x0_next = q1;
                x2_next = XW'(r1);
                dims_ok = (q1 < item.ext1) && (r1 < item.ext2);
            end
            pfa_pkg::RANK_3D:
            begin
                x0_next = q1;
                x1_next = q2;
                x2_next = r2;
                dims_ok = (q1 < item.ext1) && (q2 < item.ext2) && (r2 < XW'(item.ext3));
            end
        endcase
        in_range   = pfa_pkg::NUMEL_W'(item.idx) < cfg.numel;
        real_batch = CMP_W'(batch) < CMP_W'(cfg.batch_count);
    end

    assign stride0 = (cfg.rank == pfa_pkg::RANK_3D) ? a_e23_reg : (2*LW)'(a_e2_reg);
    assign src_sum = SUM_W'(b_bx_reg) + b_m0_reg + SUM_W'(b_m1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg && b_keep_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_keep_reg   <= rank_ok && in_range;
            a_inside_reg <= dims_ok && real_batch;
            a_x0_reg     <= x0_next;
            a_x1_reg     <= x1_next;
            a_x2_reg     <= x2_next;
            a_e2_reg     <= item.ext2;
            a_e3_reg     <= item.ext3;
            a_e23_reg    <= (2*LW)'(item.ext2) * (2*LW)'(item.ext3);
            // batch * block size, split so each product stays narrow
            a_dlo_reg    <= DLO_W'(batch) * DLO_W'(numel_w[15:0]);
            a_dhi_reg    <= DHI_W'(batch) * DHI_W'(numel_w[16 +: NHI_W]);
            a_idx_reg    <= item.idx;
            a_base_reg   <= item.base;

            b_keep_reg   <= a_keep_reg;
            b_inside_reg <= a_inside_reg;
            b_m0_reg     <= SUM_W'(a_x0_reg) * SUM_W'(stride0);
            b_m1_reg     <= (2*LW)'(a_x1_reg) * (2*LW)'(a_e3_reg);
            b_bx_reg     <= (XW+1)'(a_base_reg) + (XW+1)'(a_x2_reg);
            b_dest_reg   <= AW'(a_dlo_reg) + (AW'(a_dhi_reg) << 16) + AW'(a_idx_reg);

            c_dest_reg   <= b_dest_reg;
            c_src_reg    <= b_inside_reg ? src_sum[AW-1:0] : '0;
            c_pad_reg    <= !b_inside_reg;
            c_fill_reg   <= b_inside_reg ? '0 : cfg.pad_word;
        end
    end

    assign out_valid      = c_valid_reg;
    assign dest_address   = c_dest_reg;
    assign source_address = c_src_reg;
    assign is_padding     = c_pad_reg;
    assign fill_word      = c_fill_reg;

endmodule

FILE: hdl/packed_to_padded_fill_address.sv
// Top level of the padding-fill address generator.
//
// Usage: each request on the s_ stream names a batch block, a flat element index
// inside its padded block, the batch's packed base and its real extents. The
// block answers on the m_ stream with the destination address, and either the
// packed source address (m_tuser low) or the fill word (m_tuser high). An index
// at or past the padded block size, or rank zero, produces no result.
// Configuration goes through the cfg_ channel, which is always ready; write it
// only while no request is in flight.
// Throughput: one request per cycle while s_tready is high. Each accepted request
// passes an input register, two 16-stage divider pipelines (one quotient bit per
// stage), three address stages and the output register on its way to m_tvalid.
// Reset clears all valid bits and loads rank 1, all padded extents 1, zero real
// batches and a zero fill word.
// When m_tready is low, the output register holds its result and one more lands
// in a skid register; only then does s_tready drop and the pipeline freeze, so
// nothing is lost or repeated.
module packed_to_padded_fill_address
#(
    parameter int ADDRESS_WIDTH     = 31,
    parameter int BATCH_INDEX_WIDTH = 12
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // batch_index, element_index, packed_base, extent_first, extent_second,
    // extent_third, zero fill
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((BATCH_INDEX_WIDTH + pfa_pkg::ITEM_W + 7) / 8) * 8 - 1:0] s_tdata,
    // dest_address, source_address, fill_word, zero fill
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((2 * ADDRESS_WIDTH + pfa_pkg::WORD_W + 7) / 8) * 8 - 1:0] m_tdata,
    // is_padding
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW       = ADDRESS_WIDTH;
    localparam int BIW      = BATCH_INDEX_WIDTH;
    localparam int LW       = pfa_pkg::LEN_W;
    localparam int XW       = pfa_pkg::IDX_W;
    localparam int ITEM_W   = pfa_pkg::ITEM_W;
    localparam int M_W      = ((2 * AW + pfa_pkg::WORD_W + 7) / 8) * 8;
    localparam int FILL_LSB = 2 * AW;
    localparam int SIDE1_W  = BIW + ITEM_W;
    localparam int SIDE2_W  = SIDE1_W + 2 * LW;

    pfa_pkg::cfg_t           cfg;
    logic                    pipe_en;

    logic                    s0_valid_reg;
    logic [BIW-1:0]          s0_batch_reg;
    pfa_pkg::item_t          s0_item_reg;
    pfa_pkg::item_t          in_item;

    logic [pfa_pkg::PLANE_W-1:0] divisor1;
    logic                    d1_valid;
    logic [LW-1:0]           d1_quot;
    logic [XW-1:0]           d1_rem;
    logic [SIDE1_W-1:0]      d1_side;
    logic                    d2_valid;
    logic [LW-1:0]           d2_quot;
    logic [XW-1:0]           d2_rem;
    logic [SIDE2_W-1:0]      d2_side;

    logic                    calc_valid;
    logic [AW-1:0]           calc_dest;
    logic [AW-1:0]           calc_src;
    logic                    calc_pad;
    logic [pfa_pkg::WORD_W-1:0] calc_fill;
    logic [M_W-1:0]          calc_data;

    logic                    out_valid_reg;
    logic [M_W-1:0]          out_data_reg;
    logic                    out_user_reg;
    logic                    skid_valid_reg;
    logic [M_W-1:0]          skid_data_reg;
    logic                    skid_user_reg;

    assign cfg_ready = 1'b1;

    pfa_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Whole pipeline advances together; the skid register absorbs the one
    // result that arrives while the output is stalled.
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    always_comb
    begin
        in_item.idx  = s_tdata[BIW +: XW];
        in_item.base = s_tdata[BIW + XW +: XW];
        in_item.ext1 = s_tdata[BIW + 2 * XW +: LW];
        in_item.ext2 = s_tdata[BIW + 2 * XW + LW +: LW];
        in_item.ext3 = s_tdata[BIW + 2 * XW + 2 * LW +: LW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s0_batch_reg <= s_tdata[BIW-1:0];
            s0_item_reg  <= in_item;
        end
    end

    // First split: by the plane size in 3D, by the row length in 2D.
    assign divisor1 = (cfg.rank == pfa_pkg::RANK_3D) ? cfg.plane
                                                      : pfa_pkg::PLANE_W'(cfg.len_b);

    pfa_div_pipe
    #(
        .DVD_W  (XW),
        .DVS_W  (pfa_pkg::PLANE_W),
        .QUOT_W (LW),
        .SIDE_W (SIDE1_W)
    )
    u_div_outer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s0_valid_reg),
        .dividend  (s0_item_reg.idx),
        .divisor   (divisor1),
        .side_in   ({s0_batch_reg, s0_item_reg}),
        .out_valid (d1_valid),
        .quotient  (d1_quot),
        .remainder (d1_rem),
        .side_out  (d1_side)
    );

    pfa_div_pipe
    #(
        .DVD_W  (XW),
        .DVS_W  (LW),
        .QUOT_W (LW),
        .SIDE_W (SIDE2_W)
    )
    u_div_inner
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (d1_valid),
        .dividend  (d1_rem),
        .divisor   (cfg.len_c),
        .side_in   ({d1_side, d1_quot, d1_rem[LW-1:0]}),
        .out_valid (d2_valid),
        .quotient  (d2_quot),
        .remainder (d2_rem),
        .side_out  (d2_side)
    );

    pfa_addr_calc
    #(
        .AW  (AW),
        .BIW (BIW)
    )
    u_calc
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (pipe_en),
        .in_valid       (d2_valid),
        .batch          (d2_side[SIDE2_W-1 -: BIW]),
        .item           (pfa_pkg::item_t'(d2_side[2 * LW +: ITEM_W])),
        .q1             (d2_side[LW +: LW]),
        .r1             (d2_side[LW-1:0]),
        .q2             (d2_quot),
        .r2             (d2_rem),
        .cfg            (cfg),
        .out_valid      (calc_valid),
        .dest_address   (calc_dest),
        .source_address (calc_src),
        .is_padding     (calc_pad),
        .fill_word      (calc_fill)
    );

    assign calc_data = M_W'({calc_fill, calc_src, calc_dest});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (calc_valid)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end
        else if (calc_valid)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_data_reg <= calc_data;
                skid_user_reg <= calc_pad;
            end
            else
            begin
                out_data_reg <= calc_data;
                out_user_reg <= calc_pad;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`include "packed_to_padded_fill_address_defines.svh"

    `PFA_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with empty output")
    `PFA_ASSERT_NXT(a_skid_drains, skid_valid_reg && m_tready, out_valid_reg && !skid_valid_reg, "skid did not drain")
    `PFA_ASSERT_IMP(a_copy_no_fill, m_tvalid && !m_tuser, m_tdata[FILL_LSB +: pfa_pkg::WORD_W] == '0, "copy result carries fill word")
    `PFA_ASSERT_IMP(a_pad_no_src, m_tvalid && m_tuser, m_tdata[AW +: AW] == '0, "padding result carries source address")

endmodule
